// File: hdl/ftc_pkg.sv
// Shared types and constants for the FIFO cache with time-to-live expiry.
`default_nettype none
package ftc_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WRITE  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  // Configuration register indexes.
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_TTL      = 1'b1;

  // Request kinds carried in tuser.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_EXPIRE = 1'b1;

  // Register reset values.
  localparam logic [4:0]  CAP_RESET = 5'd16;
  localparam logic [31:0] TTL_RESET = 32'd60;

  // Result word, listed here from the highest bit down.
  typedef struct packed {
    logic [2:0]  pad;
    logic [4:0]  occupancy;
    logic [4:0]  expired_count;
    logic [31:0] evicted_key;
    logic        evicted_valid;
    logic        was_duplicate;
    logic        inserted;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/ftc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ftc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: hdl/fifo_ttl_cache.sv
// Top level of the FIFO cache with time-to-live expiry.
//
// The block keeps up to MAX_ENTRIES keys in insertion order, each with the
// time at which it was inserted. Requests arrive on the slave stream: tuser
// carries the request kind (insert or expire), tdata carries the key and the
// current time. Every request produces exactly one result word on the master
// stream with the insert, duplicate and eviction flags, the evicted key, the
// number of expired entries and the occupancy after the request.
// One sequencer walks the stored entries from the oldest one, reading one
// entry a cycle from the entry RAM and feeding a single compare unit (key
// match for an insert, stamp plus time-to-live against now for an expire).
// A duplicate or a live oldest entry ends the walk early. A new word is
// accepted only when the sequencer is idle, which may be while the previous
// result still waits in the output register; a stalled receiver holds the
// result there and the next request then stops just before delivery.
// Reset clears the occupancy, the oldest pointer and the output valid, and
// loads the default capacity and time-to-live; the entry RAM is not cleared.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none
module fifo_ttl_cache
  import ftc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // Request stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // key [31:0], now [63:32]
  input  wire logic        s_axis_tuser_i,   // action [0]
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // inserted [0], was_duplicate [1], evicted_valid [2], evicted_key [34:3],
  // expired_count [39:35], occupancy [44:40], zero padding [47:45]
  output logic [47:0]      m_axis_tdata_o
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_ENTRIES);

  // Configuration registers.
  logic [4:0]  cap_q;
  logic [31:0] ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      ttl_q <= TTL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAPACITY: cap_q <= cfg_data_i[4:0];
        CFG_TTL:      ttl_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Sequencer and store bookkeeping.
  state_e           state_q, state_d;
  logic [IDX_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             pend_q, pend_d;
  logic             first_q, first_d;
  logic [CNT_W-1:0] expired_q, expired_d;
  logic             act_q, act_d;
  logic [31:0]      key_q, key_d;
  logic [31:0]      now_q, now_d;
  logic [31:0]      evkey_q, evkey_d;
  logic             r_ins_q, r_ins_d;
  logic             r_dup_q, r_dup_d;
  logic             r_ev_q, r_ev_d;
  logic [31:0]      r_evkey_q, r_evkey_d;
  logic             m_valid_q, m_valid_d;
  result_t          m_data_q, m_data_d;

  // Entry RAM: stamp in the upper half, key in the lower half.
  logic             ram_we;
  logic             ram_re;
  logic [63:0]      ram_rdata;
  logic [31:0]      rd_key;
  logic [31:0]      rd_stamp;

  ftc_ram #(
    .WIDTH (64),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i ({now_q, key_q}),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_key   = ram_rdata[31:0];
  assign rd_stamp = ram_rdata[63:32];

  // The shared compare unit: a key match for inserts, an age test for expiry.
  logic        key_match;
  logic        stale;
  logic [32:0] limit;

  assign limit     = {1'b0, rd_stamp} + {1'b0, ttl_q};
  assign stale     = limit < {1'b0, now_q};
  assign key_match = rd_key == key_q;

  // Capacity in use, clamped to one and to the store depth.
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] count_ext;
  logic             evict;

  assign cap_ext   = CMP_W'(cap_q);
  assign eff_cap   = (cap_q == 5'd0) ? CMP_W'(1) :
                     (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;
  assign count_ext = CMP_W'(count_q);
  assign evict     = (count_ext >= eff_cap) && (count_q != '0);

  logic             issue_ok;
  logic [IDX_W-1:0] ptr_inc;
  logic [IDX_W-1:0] oldest_inc;
  logic             in_acc;
  logic             out_free;

  assign issue_ok   = issue_q < n_q;
  assign ptr_inc    = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
  assign oldest_inc = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
  assign s_axis_tready_o = state_q == ST_IDLE;
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    oldest_d  = oldest_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    issue_d   = issue_q;
    n_d       = n_q;
    pend_d    = 1'b0;
    first_d   = first_q;
    expired_d = expired_q;
    act_d     = act_q;
    key_d     = key_q;
    now_d     = now_q;
    evkey_d   = evkey_q;
    r_ins_d   = r_ins_q;
    r_dup_d   = r_dup_q;
    r_ev_d    = r_ev_q;
    r_evkey_d = r_evkey_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          act_d     = s_axis_tuser_i;
          key_d     = s_axis_tdata_i[31:0];
          now_d     = s_axis_tdata_i[63:32];
          ptr_d     = oldest_q;
          issue_d   = '0;
          n_d       = count_q;
          first_d   = 1'b1;
          expired_d = '0;
          evkey_d   = '0;
          r_ins_d   = 1'b0;
          r_dup_d   = 1'b0;
          r_ev_d    = 1'b0;
          r_evkey_d = '0;
          state_d   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (act_q == ACT_INSERT) begin
          // The first entry read back is the oldest, kept for eviction.
          if (pend_q && first_q) begin
            evkey_d = rd_key;
            first_d = 1'b0;
          end
          if (pend_q && key_match) begin
            r_dup_d = 1'b1;
            state_d = ST_RESULT;
          end else if (issue_ok) begin
            ram_re  = 1'b1;
            pend_d  = 1'b1;
            ptr_d   = ptr_inc;
            issue_d = issue_q + 1'b1;
          end else if (!pend_q) begin
            // Walk done with no match; ptr_q now points just past the newest entry.
            state_d = ST_WRITE;
          end
        end else begin
          if (pend_q && stale) begin
            oldest_d  = oldest_inc;
            count_d   = count_q - 1'b1;
            expired_d = expired_q + 1'b1;
          end
          if (pend_q && !stale) begin
            state_d = ST_RESULT;
          end else if (issue_ok) begin
            ram_re  = 1'b1;
            pend_d  = 1'b1;
            ptr_d   = ptr_inc;
            issue_d = issue_q + 1'b1;
          end else if (!pend_q) begin
            state_d = ST_RESULT;
          end
        end
      end

      ST_WRITE: begin
        // Evicting the oldest and appending share a slot only when the store is full.
        ram_we  = 1'b1;
        r_ins_d = 1'b1;
        if (evict) begin
          r_ev_d    = 1'b1;
          r_evkey_d = evkey_q;
          oldest_d  = oldest_inc;
        end else begin
          count_d = count_q + 1'b1;
        end
        state_d = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_free) begin
          m_valid_d              = 1'b1;
          m_data_d.pad           = '0;
          m_data_d.occupancy     = 5'(count_q);
          m_data_d.expired_count = 5'(expired_q);
          m_data_d.evicted_key   = r_evkey_q;
          m_data_d.evicted_valid = r_ev_q;
          m_data_d.was_duplicate = r_dup_q;
          m_data_d.inserted      = r_ins_q;
          state_d                = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      oldest_q  <= '0;
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    issue_q   <= issue_d;
    n_q       <= n_d;
    first_q   <= first_d;
    expired_q <= expired_d;
    act_q     <= act_d;
    key_q     <= key_d;
    now_q     <= now_d;
    evkey_q   <= evkey_d;
    r_ins_q   <= r_ins_d;
    r_dup_q   <= r_dup_d;
    r_ev_q    <= r_ev_d;
    r_evkey_q <= r_evkey_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Occupancy never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= MAX_CMP)
    else $error("occupancy above store depth");

  // An accepted request always starts the entry walk.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_SCAN)
    else $error("accepted request did not start the walk");

  // RAM read data is only pending while the walk runs.
  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_SCAN)
    else $error("read pending outside the walk");

  // An insert result is never both stored and a duplicate.
  a_ins_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q.inserted && m_data_q.was_duplicate))
    else $error("result both inserted and duplicate");

  // An eviction is only reported together with a stored key.
  a_ev_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q.evicted_valid |-> m_data_q.inserted)
    else $error("eviction without insert");

endmodule
`default_nettype wire
